// File: sv/jqbd_pkg.sv
// Shared types, codes and defaults for the job queue barrier dispatcher.
// No dependencies.
package jqbd_pkg;

  localparam int WAIT_DEPTH_DEF = 16;
  localparam int RUN_DEPTH_DEF  = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int CFG_AW         = 3;
  localparam logic [4:0] MAX_RUNNING_RST = 5'd1;

  typedef logic [1:0] req_t;
  localparam req_t REQ_ADD  = 2'd0;
  localparam req_t REQ_FIN  = 2'd1;
  localparam req_t REQ_DISP = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ADD   = 2'd0;
  localparam kind_t KIND_FIN   = 2'd1;
  localparam kind_t KIND_START = 2'd2;
  localparam kind_t KIND_NONE  = 2'd3;

  typedef logic [1:0] stat_code_t;
  localparam stat_code_t ST_QUEUED      = 2'd0;
  localparam stat_code_t ST_MERGED_REDO = 2'd1;
  localparam stat_code_t ST_MERGED_LAST = 2'd2;
  localparam stat_code_t ST_QFULL       = 2'd3;
  localparam stat_code_t ST_OK          = 2'd0;
  localparam stat_code_t ST_REQUEUED    = 2'd1;
  localparam stat_code_t ST_UNKNOWN     = 2'd2;
  localparam stat_code_t ST_WQFULL      = 2'd3;

  localparam logic [CFG_AW-1:0] ADDR_MAX_RUNNING = 3'd0;

  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  handle;
    logic        redo;
  } ent_t;

  typedef struct packed {
    logic       latch_in;
    logic       widx_inc;
    logic       widx_clr;
    logic       ridx_inc;
    logic       ridx_clr;
    logic       n_from_widx;
    logic       n_dec;
    logic       w_set_redo;
    logic       w_push_in;
    logic       w_push_run;
    logic       r_free;
    logic       r_start;
    logic       out_load;
    kind_t      kind;
    stat_code_t status;
    logic       last;
    logic       use_fin;
  } cmd_t;

  typedef struct packed {
    logic tag_zero;
    logic w_match;
    logic widx_last;
    logic widx_end;
    logic widx_zero;
    logic wfull;
    logic head_tag_nz;
    logic r_match;
    logic r_valid;
    logic ridx_end;
    logic r_redo;
    logic disp_end;
    logic rtag_any;
    logic busy_n;
    logic n_one;
    logic out_free;
  } dstat_t;

endpackage

// File: sv/jqbd_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on jqbd_pkg.
interface jqbd_in_if;
  import jqbd_pkg::*;
  logic        valid;
  logic        ready;
  req_t        req_type;
  logic [15:0] sync_tag;
  logic [7:0]  job_handle;
  modport source (output valid, req_type, sync_tag, job_handle, input ready);
  modport sink   (input valid, req_type, sync_tag, job_handle, output ready);
endinterface

interface jqbd_out_if;
  import jqbd_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       result_kind;
  stat_code_t  status;
  logic [7:0]  started_handle;
  logic        last_result;
  logic [4:0]  running_count;
  logic [5:0]  remaining_count;
  modport source (output valid, result_kind, status, started_handle, last_result,
                  running_count, remaining_count, input ready);
  modport sink   (input valid, result_kind, status, started_handle, last_result,
                  running_count, remaining_count, output ready);
endinterface

// File: sv/job_queue_barrier_dispatcher.sv
// Job dispatcher top level: one item at a time through a controller and datapath.
// An untagged add is pushed at once; a tagged add first searches the wait entries.
// A finish scans the run slots; a dispatch counts head entries, then scans for a
// free slot per start. Next item is accepted once
// the last result is loaded. The walks read the wait and run memories through registers.
// Sync active-low reset empties both tables and sets max_running to 1; no clearing pass.
module job_queue_barrier_dispatcher #(
  parameter int WAIT_DEPTH = jqbd_pkg::WAIT_DEPTH_DEF,
  parameter int RUN_DEPTH  = jqbd_pkg::RUN_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  jqbd_in_if.sink                     in_ch,
  jqbd_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [jqbd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import jqbd_pkg::*;

  logic [4:0] max_running_r;
  cmd_t       cmd;
  dstat_t     st;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_MAX_RUNNING) ? {27'd0, max_running_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) max_running_r <= MAX_RUNNING_RST;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_MAX_RUNNING)
      max_running_r <= cfg_pwdata[4:0];
  end

  jqbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_req   (in_ch.req_type),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  jqbd_datapath #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .RUN_DEPTH  (RUN_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_tag      (in_ch.sync_tag),
    .in_handle   (in_ch.job_handle),
    .max_running (max_running_r),
    .out_ch      (out_ch)
  );

endmodule

// File: sv/jqbd_datapath.sv
// Datapath: wait queue memory, run table memory with valid bits, counters,
// scan indexes and the result register. Depends on jqbd_pkg, jqbd_if.
module jqbd_datapath #(
  parameter int WAIT_DEPTH = jqbd_pkg::WAIT_DEPTH_DEF,
  parameter int RUN_DEPTH  = jqbd_pkg::RUN_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  jqbd_pkg::cmd_t    cmd,
  output jqbd_pkg::dstat_t  st,
  input  logic [15:0]       in_tag,
  input  logic [7:0]        in_handle,
  input  logic [4:0]        max_running,
  jqbd_out_if.source        out_ch
);
  import jqbd_pkg::*;

  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int WCW = WAW + 1;
  localparam int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int RCW = $clog2(RUN_DEPTH + 1);
  localparam int RIW = RAW + 1;
  localparam int NW  = $clog2(MAX_RESULTS + 1);

  ent_t wmem [WAIT_DEPTH];
  ent_t rmem [RUN_DEPTH];
  ent_t wrd_r, rrd_r;

  logic [WAW-1:0] whead_r;
  logic [WCW-1:0] wcnt_r, widx_r;
  logic [RCW-1:0] rcnt_r, rtag_r, fin_run_r;
  logic [RIW-1:0] ridx_r;
  logic [NW-1:0]  n_r;
  logic [RUN_DEPTH-1:0] valid_r;
  logic [15:0] tag_r;
  logic [7:0]  handle_r;

  logic        oval_r;
  kind_t       okind_r;
  stat_code_t  ostat_r;
  logic [7:0]  ohandle_r;
  logic        olast_r;
  logic [4:0]  orun_r;
  logic [5:0]  orem_r;

  logic [WCW:0]   rd_sum, push_sum;
  logic [WAW-1:0] raddr, paddr;
  logic [RAW-1:0] ridx_i;
  logic [31:0]    limit, busy_sum;
  logic           wwe;
  ent_t           wwd;
  logic [WAW-1:0] wwa;

  // modulo add: the head stays below the depth and the count at most equals it, so one subtract
  assign rd_sum   = {1'b0, WCW'(whead_r)} + {1'b0, widx_r};
  assign push_sum = {1'b0, WCW'(whead_r)} + {1'b0, wcnt_r};
  assign raddr = (rd_sum >= (WCW+1)'(WAIT_DEPTH)) ?
                 WAW'(rd_sum - (WCW+1)'(WAIT_DEPTH)) : WAW'(rd_sum);
  assign paddr = (push_sum >= (WCW+1)'(WAIT_DEPTH)) ?
                 WAW'(push_sum - (WCW+1)'(WAIT_DEPTH)) : WAW'(push_sum);
  assign ridx_i = ridx_r[RAW-1:0];

  assign limit    = (32'(max_running) > 32'(RUN_DEPTH)) ? 32'(RUN_DEPTH) : 32'(max_running);
  assign busy_sum = 32'(rcnt_r) + 32'(widx_r);

  always_comb begin
    st.tag_zero    = (tag_r == 16'd0);
    st.w_match     = (wrd_r.tag == tag_r);
    st.widx_last   = (32'(widx_r) + 32'd1) == 32'(wcnt_r);
    st.widx_end    = (widx_r == wcnt_r);
    st.widx_zero   = (widx_r == '0);
    st.wfull       = (wcnt_r == WCW'(WAIT_DEPTH));
    st.head_tag_nz = (wrd_r.tag != 16'd0);
    st.ridx_end    = (ridx_r == RIW'(RUN_DEPTH));
    st.r_valid     = st.ridx_end ? 1'b1 : valid_r[ridx_i];
    st.r_match     = !st.ridx_end && valid_r[ridx_i] && (rrd_r.handle == handle_r);
    st.r_redo      = rrd_r.redo;
    st.disp_end    = st.widx_end || (busy_sum >= limit) || (32'(widx_r) == MAX_RESULTS);
    st.rtag_any    = (rtag_r != '0);
    st.busy_n      = (busy_sum != 32'd0);
    st.n_one       = (n_r == NW'(1));
    st.out_free    = !oval_r || out_ch.ready;
  end

  always_comb begin
    wwe = cmd.w_set_redo || cmd.w_push_in || cmd.w_push_run;
    wwa = paddr;
    wwd = '{tag: tag_r, handle: handle_r, redo: 1'b0};
    if (cmd.w_set_redo) begin
      wwa = raddr;
      wwd = '{tag: wrd_r.tag, handle: wrd_r.handle, redo: 1'b1};
    end else if (cmd.w_push_run) begin
      wwd = '{tag: rrd_r.tag, handle: rrd_r.handle, redo: 1'b0};
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (wwe) wmem[wwa] <= wwd;
    wrd_r <= wmem[raddr];
    if (cmd.r_start) rmem[ridx_i] <= wrd_r;
    rrd_r <= rmem[ridx_i];
    if (cmd.latch_in) begin
      tag_r    <= in_tag;
      handle_r <= in_handle;
    end
    if (cmd.n_from_widx) fin_run_r <= RCW'(busy_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whead_r <= '0;
      wcnt_r  <= '0;
      widx_r  <= '0;
      rcnt_r  <= '0;
      rtag_r  <= '0;
      ridx_r  <= '0;
      n_r     <= '0;
      valid_r <= '0;
      oval_r  <= 1'b0;
    end else begin
      if (cmd.latch_in || cmd.widx_clr) widx_r <= '0;
      else if (cmd.widx_inc) widx_r <= widx_r + WCW'(1);
      if (cmd.latch_in || cmd.ridx_clr) ridx_r <= '0;
      else if (cmd.ridx_inc) ridx_r <= ridx_r + RIW'(1);
      if (cmd.n_from_widx) n_r <= NW'(widx_r);
      else if (cmd.n_dec) n_r <= n_r - NW'(1);
      if (cmd.w_push_in || cmd.w_push_run) wcnt_r <= wcnt_r + WCW'(1);
      if (cmd.r_free) begin
        valid_r[ridx_i] <= 1'b0;
        rcnt_r <= rcnt_r - RCW'(1);
        if (rrd_r.tag != 16'd0) rtag_r <= rtag_r - RCW'(1);
      end
      if (cmd.r_start) begin
        valid_r[ridx_i] <= 1'b1;
        rcnt_r <= rcnt_r + RCW'(1);
        if (wrd_r.tag != 16'd0) rtag_r <= rtag_r + RCW'(1);
        whead_r <= (whead_r == WAW'(WAIT_DEPTH - 1)) ? '0 : whead_r + WAW'(1);
        wcnt_r <= wcnt_r - WCW'(1);
      end
      if (cmd.out_load) oval_r <= 1'b1;
      else if (out_ch.ready) oval_r <= 1'b0;
    end
  end

  // result payload; counts are taken after the item's updates have landed
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      okind_r <= cmd.kind;
      ostat_r <= cmd.status;
      olast_r <= cmd.last;
      orun_r  <= cmd.use_fin ? 5'(fin_run_r) : 5'(rcnt_r);
      orem_r  <= 6'(32'(rcnt_r) + 32'(wcnt_r));
      case (cmd.kind)
        KIND_START: ohandle_r <= wrd_r.handle;
        KIND_NONE:  ohandle_r <= 8'd0;
        default:    ohandle_r <= handle_r;
      endcase
    end
  end

  assign out_ch.valid           = oval_r;
  assign out_ch.result_kind     = okind_r;
  assign out_ch.status          = ostat_r;
  assign out_ch.started_handle  = ohandle_r;
  assign out_ch.last_result     = olast_r;
  assign out_ch.running_count   = orun_r;
  assign out_ch.remaining_count = orem_r;

endmodule

// File: sv/jqbd_ctrl.sv
// Controller: sequences add search, finish scan, dispatch count and start passes.
// Depends on jqbd_pkg.
module jqbd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  jqbd_pkg::req_t     in_req,
  output logic               in_ready,
  input  jqbd_pkg::dstat_t   st,
  output jqbd_pkg::cmd_t     cmd
);
  import jqbd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, A_CHK, A_RD, A_EVAL, A_PUSH,
    F_CHK, F_RD, F_EVAL, F_PUSH,
    D_START, D_CHK, D_RD, D_EVAL, D_DONE, P_SCAN, P_EMIT, S_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  kind_t      kind_r, kind_nxt;
  stat_code_t stat_r, stat_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    stat_nxt  = stat_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_req)
            REQ_ADD:  state_nxt = S_ADD;
            REQ_FIN:  state_nxt = F_CHK;
            REQ_DISP: state_nxt = D_START;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD:  state_nxt = st.tag_zero ? A_PUSH : A_CHK;
      A_CHK:  state_nxt = st.widx_end ? A_PUSH : A_RD;
      A_RD:   state_nxt = A_EVAL;
      A_EVAL: begin
        if (st.w_match) begin
          kind_nxt = KIND_ADD;
          if (st.widx_last) stat_nxt = ST_MERGED_LAST;
          else begin
            cmd.w_set_redo = 1'b1;
            stat_nxt = ST_MERGED_REDO;
          end
          state_nxt = S_EMIT;
        end else begin
          cmd.widx_inc = 1'b1;
          state_nxt = A_CHK;
        end
      end
      A_PUSH: begin
        kind_nxt = KIND_ADD;
        if (st.wfull) stat_nxt = ST_QFULL;
        else begin
          cmd.w_push_in = 1'b1;
          stat_nxt = ST_QUEUED;
        end
        state_nxt = S_EMIT;
      end
      F_CHK: begin
        if (st.ridx_end) begin
          kind_nxt  = KIND_FIN;
          stat_nxt  = ST_UNKNOWN;
          state_nxt = S_EMIT;
        end else state_nxt = F_RD;
      end
      F_RD:   state_nxt = F_EVAL;
      F_EVAL: begin
        if (st.r_match) begin
          cmd.r_free = 1'b1;
          kind_nxt = KIND_FIN;
          stat_nxt = ST_OK;
          state_nxt = st.r_redo ? F_PUSH : S_EMIT;
        end else begin
          cmd.ridx_inc = 1'b1;
          state_nxt = F_CHK;
        end
      end
      F_PUSH: begin
        if (st.wfull) stat_nxt = ST_WQFULL;
        else begin
          cmd.w_push_run = 1'b1;
          stat_nxt = ST_REQUEUED;
        end
        state_nxt = S_EMIT;
      end
      D_START: begin
        if (st.rtag_any) begin
          kind_nxt  = KIND_NONE;
          stat_nxt  = ST_OK;
          state_nxt = S_EMIT;
        end else state_nxt = D_CHK;
      end
      D_CHK:  state_nxt = st.disp_end ? D_DONE : D_RD;
      D_RD:   state_nxt = D_EVAL;
      D_EVAL: begin
        // tagged entry only starts into an empty run table with no entry counted before it, and then ends the walk
        if (st.head_tag_nz && st.busy_n) state_nxt = D_DONE;
        else begin
          cmd.widx_inc = 1'b1;
          state_nxt = st.head_tag_nz ? D_DONE : D_CHK;
        end
      end
      D_DONE: begin
        if (st.widx_zero) begin
          kind_nxt  = KIND_NONE;
          stat_nxt  = ST_OK;
          state_nxt = S_EMIT;
        end else begin
          cmd.n_from_widx = 1'b1;
          cmd.widx_clr = 1'b1;
          cmd.ridx_clr = 1'b1;
          state_nxt = P_SCAN;
        end
      end
      P_SCAN: begin
        if (st.r_valid) cmd.ridx_inc = 1'b1;
        else state_nxt = P_EMIT;
      end
      P_EMIT: begin
        if (st.out_free) begin
          cmd.r_start  = 1'b1;
          cmd.out_load = 1'b1;
          cmd.kind     = KIND_START;
          cmd.status   = ST_OK;
          cmd.last     = st.n_one;
          cmd.use_fin  = 1'b1;
          cmd.n_dec    = 1'b1;
          cmd.ridx_clr = 1'b1;
          state_nxt = st.n_one ? S_IDLE : P_SCAN;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.kind     = kind_r;
          cmd.status   = stat_r;
          cmd.last     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= KIND_ADD;
      stat_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

// File: tb/job_queue_barrier_dispatcher_tb.sv
// Self-checking bench for job_queue_barrier_dispatcher: directed and random job traffic,
// scoreboarded against a behavioral dispatcher model. Depends on jqbd_pkg and jqbd_if.
module job_queue_barrier_dispatcher_tb;
  import jqbd_pkg::*;

  localparam int WD = 16;
  localparam int RD = 16;
  localparam int CYCLE_LIMIT = 900000;
  localparam int HOLD_CYCLES = 400;
  localparam req_t REQ_UNUSED = 2'd3;

  typedef struct packed {
    req_t        req;
    logic [15:0] tag;
    logic [7:0]  handle;
  } job_req_t;

  typedef struct packed {
    kind_t       kind;
    stat_code_t  status;
    logic [7:0]  handle;
    logic        last;
    logic [4:0]  nrun;
    logic [5:0]  nrem;
  } job_res_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    logic [7:0]  handle;
    logic        redo;
  } run_slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  jqbd_in_if  in_ch();
  jqbd_out_if out_ch();

  job_queue_barrier_dispatcher uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // model state
  ent_t      wq [WD];
  int        wq_head = 0, wq_cnt = 0;
  run_slot_t runs [RD] = '{default: '0};
  int        run_cnt = 0;
  int        limit_cfg = MAX_RUNNING_RST;

  job_req_t  pending_jobs[$];
  job_res_t  expected_results[$];
  int        fails = 0;
  int        cycles = 0;
  int        hold_off = 0;
  int        hold_req = 0;
  int        hold_ack = 0;

  function automatic bit wq_push(logic [15:0] t, logic [7:0] h);
    if (wq_cnt >= WD) return 0;
    wq[(wq_head + wq_cnt) % WD] = '{tag: t, handle: h, redo: 1'b0};
    wq_cnt++;
    return 1;
  endfunction

  function automatic bit any_tagged_run();
    for (int i = 0; i < RD; i++)
      if (runs[i].valid && runs[i].tag != 0) return 1;
    return 0;
  endfunction

  function automatic void emit(kind_t k, stat_code_t s, logic [7:0] h);
    job_res_t r;
    r.kind = k; r.status = s; r.handle = h; r.last = 1'b0; r.nrun = '0; r.nrem = '0;
    expected_results.push_back(r);
  endfunction

  task automatic dispatch_job(job_req_t j);
    int base, n, lim, slot, p;
    bit merged;
    stat_code_t st;
    base = expected_results.size();
    n = 0;
    case (j.req)
      REQ_ADD: begin
        merged = 0;
        st = ST_QUEUED;
        if (j.tag != 0)
          for (int i = 0; i < wq_cnt && !merged; i++) begin
            p = (wq_head + i) % WD;
            if (wq[p].tag == j.tag) begin
              merged = 1;
              if (i + 1 < wq_cnt) begin
                wq[p].redo = 1'b1;
                st = ST_MERGED_REDO;
              end else st = ST_MERGED_LAST;
            end
          end
        if (!merged) st = wq_push(j.tag, j.handle) ? ST_QUEUED : ST_QFULL;
        emit(KIND_ADD, st, j.handle);
        n = 1;
      end
      REQ_FIN: begin
        st = ST_UNKNOWN;
        for (int i = 0; i < RD; i++)
          if (runs[i].valid && runs[i].handle == j.handle) begin
            runs[i].valid = 1'b0;
            run_cnt--;
            st = ST_OK;
            if (runs[i].redo) begin
              runs[i].redo = 1'b0;
              st = wq_push(runs[i].tag, runs[i].handle) ? ST_REQUEUED : ST_WQFULL;
            end
            break;
          end
        emit(KIND_FIN, st, j.handle);
        n = 1;
      end
      REQ_DISP: begin
        lim = limit_cfg > RD ? RD : limit_cfg;
        while (wq_cnt > 0 && run_cnt < lim && n < 16) begin
          if (wq[wq_head].tag != 0 && run_cnt > 0) break;
          if (any_tagged_run()) break;
          slot = RD;
          for (int s = RD - 1; s >= 0; s--) if (!runs[s].valid) slot = s;
          if (slot >= RD) break;
          runs[slot] = '{valid: 1'b1, tag: wq[wq_head].tag, handle: wq[wq_head].handle,
                         redo: wq[wq_head].redo};
          run_cnt++;
          wq_head = (wq_head + 1) % WD;
          wq_cnt--;
          emit(KIND_START, ST_OK, runs[slot].handle);
          n++;
        end
        if (n == 0) begin
          emit(KIND_NONE, ST_OK, 8'd0);
          n = 1;
        end
      end
      default: ;
    endcase
    for (int k = base; k < base + n; k++) begin
      expected_results[k].last = (k == base + n - 1);
      expected_results[k].nrun = run_cnt[4:0];
      expected_results[k].nrem = 6'(run_cnt + wq_cnt);
    end
  endtask

  // driver
  int in_gap = 0;
  bit in_sent = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.req_type <= REQ_ADD;
      in_ch.sync_tag <= '0;
      in_ch.job_handle <= '0;
    end else if (!in_ch.valid || in_sent) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_jobs.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.req_type <= pending_jobs[0].req;
        in_ch.sync_tag <= pending_jobs[0].tag;
        in_ch.job_handle <= pending_jobs[0].handle;
        void'(pending_jobs.pop_front());
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end else in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_sent <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      job_req_t j;
      j.req = in_ch.req_type; j.tag = in_ch.sync_tag; j.handle = in_ch.job_handle;
      dispatch_job(j);
    end
  end

  // receiver stalls
  int out_gap = 0;
  bit out_taken = 0;
  always @(negedge clk) begin : rx
    int d;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (out_taken) begin
      d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_ch.ready <= (d == 0);
      out_gap <= (d == 0) ? 0 : d - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d handle=%0d", out_ch.result_kind,
               out_ch.started_handle);
        fails++;
      end else begin
        job_res_t e;
        e = expected_results.pop_front();
        if (out_ch.result_kind !== e.kind) begin
          $error("result_kind exp %0d got %0d", e.kind, out_ch.result_kind); fails++;
        end
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status); fails++;
        end
        if (out_ch.started_handle !== e.handle) begin
          $error("started_handle exp %0d got %0d", e.handle, out_ch.started_handle); fails++;
        end
        if (out_ch.last_result !== e.last) begin
          $error("last_result exp %0d got %0d", e.last, out_ch.last_result); fails++;
        end
        if (out_ch.running_count !== e.nrun) begin
          $error("running_count exp %0d got %0d", e.nrun, out_ch.running_count); fails++;
        end
        if (out_ch.remaining_count !== e.nrem) begin
          $error("remaining_count exp %0d got %0d", e.nrem, out_ch.remaining_count); fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic cfg_write(logic [31:0] v);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_MAX_RUNNING; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    limit_cfg = v & 32'h1F;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic add_job(req_t r, logic [15:0] t, logic [7:0] h);
    pending_jobs.push_back('{req: r, tag: t, handle: h});
  endtask

  task automatic drain();
    wait (pending_jobs.size() == 0 && !in_ch.valid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // mostly-sane random job: handles from small pool so finishes hit running jobs
  task automatic random_job();
    int sel;
    logic [15:0] t;
    sel = $urandom_range(0, 99);
    t = ($urandom_range(0, 2) == 0) ? 16'(0) :
        ($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(1, 4)));
    if (sel < 40) add_job(REQ_ADD, t, 8'($urandom_range(0, 15)));
    else if (sel < 65) add_job(REQ_FIN, '0, 8'($urandom_range(0, 15)));
    else if (sel < 93) add_job(REQ_DISP, 16'($urandom), 8'($urandom));
    else if (sel < 97) add_job(REQ_FIN, 16'($urandom), 8'($urandom));
    else add_job(REQ_UNUSED, 16'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset limit of one
    add_job(REQ_DISP, 16'h0, 8'h00);
    add_job(REQ_ADD, 16'h0, 8'hFF);
    add_job(REQ_ADD, 16'hFFFF, 8'h00);
    add_job(REQ_ADD, 16'h0005, 8'h11);
    add_job(REQ_ADD, 16'hFFFF, 8'h22);
    add_job(REQ_ADD, 16'h0005, 8'h33);
    add_job(REQ_DISP, 16'h0, 8'h0);
    add_job(REQ_DISP, 16'h0, 8'h0);
    add_job(REQ_FIN, 16'h0, 8'hAA);
    add_job(REQ_UNUSED, 16'hFFFF, 8'hFF);
    add_job(REQ_FIN, 16'h0, 8'hFF);
    add_job(REQ_DISP, 16'h0, 8'h0);
    add_job(REQ_DISP, 16'h0, 8'h0);
    add_job(REQ_FIN, 16'h0, 8'h00);
    drain();

    cfg_write(32'd16);
    for (int i = 0; i < 18; i++) add_job(REQ_ADD, 16'h0, 8'(i));
    // receiver held off while sender keeps pushing
    hold_req++;
    add_job(REQ_DISP, 16'h0, 8'h0);
    add_job(REQ_ADD, 16'h0, 8'h40);
    add_job(REQ_ADD, 16'h0009, 8'h41);
    add_job(REQ_DISP, 16'h0, 8'h0);
    drain();

    cfg_write(32'd0);
    add_job(REQ_DISP, 16'h0, 8'h0);
    for (int i = 0; i < 20; i++) add_job(REQ_FIN, 16'h0, 8'(i));
    drain();

    cfg_write(32'd31);
    for (int i = 0; i < 15; i++) random_job();
    drain();
    cfg_write(32'd1);
    for (int i = 0; i < 15; i++) random_job();
    drain();
    cfg_write(32'd3);
    for (int i = 0; i < 15; i++) random_job();
    for (int i = 0; i < 16; i++) add_job(REQ_FIN, 16'h0, 8'(i));
    drain();

    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
